>>> src/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg: shared types for the JSON string unescaper
// Result status codes and the command word that travels from the parser
// to the output sequencer.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // Status of one result item.
  typedef enum logic [2:0] {
    ST_BYTE    = 3'd0,
    ST_DONE    = 3'd1,
    ST_NOQUOTE = 3'd2,
    ST_UNTERM  = 3'd3,
    ST_BADHEX  = 3'd4,
    ST_BADESC  = 3'd5,
    ST_CTRL    = 3'd6
  } status_t;

  // One parsed input byte that causes results: up to three output bytes.
  // last_idx is the index of the final result (0 to 2).
  typedef struct packed {
    logic [1:0] last_idx;
    logic [7:0] byte2;
    logic [7:0] byte1;
    logic [7:0] byte0;
    status_t    status;
  } cmd_t;

endpackage

>>> src/json_string_unescape_utf8.sv
// Path: input byte -> parser -> command queue -> output register.
// Throughput: one input byte per cycle while the queue is not full; a \u
// escape that encodes to two or three bytes holds the output sequencer for
// one result per byte, and the command queue absorbs it as input flows.
// Reset: synchronous, active high; clears parser state, queue and output.
// ----------------------------------------------------------------------------
// json_string_unescape_utf8: streaming JSON string unescaper
// Parser, command queue and output sequencer in a decoupled chain.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic [2:0]  m_tuser,   // [2:0] status
  output logic        m_tlast    // last_of_run
);
  import jsu_pkg::*;

  logic    push, full, pop, not_empty;
  cmd_t    push_cmd, head_cmd;
  logic [7:0] out_byte;
  status_t    out_status;

  jsu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_byte    (s_tdata),
    .in_ready   (s_tready),
    .push       (push),
    .push_cmd   (push_cmd),
    .queue_full (full)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head_cmd  (head_cmd)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (not_empty),
    .cmd        (head_cmd),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_byte   (out_byte),
    .out_status (out_status),
    .out_last   (m_tlast)
  );

  // Drive the result fields.
  assign m_tdata = out_byte;
  assign m_tuser = out_status;

endmodule

>>> src/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front: input parser
// Walks the string grammar one byte per transfer and turns every byte that
// causes results into one command for the queue.
// ----------------------------------------------------------------------------
module jsu_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [7:0]    in_byte,
  output logic          in_ready,
  output logic          push,
  output jsu_pkg::cmd_t push_cmd,
  input  logic          queue_full
);
  import jsu_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_STR  = 2'd1,
    PH_ESC  = 2'd2,
    PH_HEX  = 2'd3
  } phase_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_N = 8'h6E;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_U = 8'h75;

  phase_t      phase, phase_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [15:0] code_point, code_point_next;

  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [15:0] cp_new;
  logic        has_result;
  cmd_t        cmd;
  logic        accept;

  // Hex digit decode.
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_val = 4'(in_byte - 8'h30);
    end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
      hex_val = 4'(in_byte - 8'h57);
    end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
      hex_val = 4'(in_byte - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign cp_new = {code_point[11:0], hex_val};

  // Grammar step and command build.
  always_comb begin
    phase_next      = phase;
    hex_count_next  = hex_count;
    code_point_next = code_point;
    has_result      = 1'b0;
    cmd             = '{last_idx: 2'd0, byte2: 8'h00, byte1: 8'h00, byte0: 8'h00,
                        status: ST_BYTE};
    case (phase)
      PH_IDLE: begin
        if (in_byte == CH_QUOTE) begin
          phase_next = PH_STR;
        end else begin
          has_result = 1'b1;
          cmd.status = ST_NOQUOTE;
        end
      end
      PH_STR: begin
        if (in_byte == CH_QUOTE) begin
          has_result = 1'b1;
          cmd.status = ST_DONE;
          phase_next = PH_IDLE;
        end else if (in_byte == 8'h00) begin
          has_result = 1'b1;
          cmd.status = ST_UNTERM;
          phase_next = PH_IDLE;
        end else if (in_byte == CH_BSLASH) begin
          phase_next = PH_ESC;
        end else if (in_byte < 8'h20) begin
          has_result = 1'b1;
          cmd.status = ST_CTRL;
          phase_next = PH_IDLE;
        end else begin
          has_result = 1'b1;
          cmd.byte0  = in_byte;
        end
      end
      PH_ESC: begin
        phase_next = PH_STR;
        has_result = 1'b1;
        case (in_byte)
          8'h00:    begin
            cmd.status = ST_UNTERM;
            phase_next = PH_IDLE;
          end
          CH_QUOTE, CH_BSLASH, CH_SLASH: cmd.byte0 = in_byte;
          CH_B:     cmd.byte0 = 8'h08;
          CH_F:     cmd.byte0 = 8'h0C;
          CH_N:     cmd.byte0 = 8'h0A;
          CH_R:     cmd.byte0 = 8'h0D;
          CH_T:     cmd.byte0 = 8'h09;
          CH_U:     begin
            has_result      = 1'b0;
            phase_next      = PH_HEX;
            hex_count_next  = 2'd0;
            code_point_next = 16'h0000;
          end
          default:  begin
            cmd.status = ST_BADESC;
            phase_next = PH_IDLE;
          end
        endcase
      end
      default: begin
        if (!hex_ok) begin
          has_result = 1'b1;
          cmd.status = ST_BADHEX;
          phase_next = PH_IDLE;
        end else if (hex_count == 2'd3) begin
          // Fourth digit: encode the code point as UTF-8.
          has_result      = 1'b1;
          phase_next      = PH_STR;
          hex_count_next  = 2'd0;
          code_point_next = 16'h0000;
          if (cp_new <= 16'h007F) begin
            cmd.byte0 = cp_new[7:0];
          end else if (cp_new <= 16'h07FF) begin
            cmd.last_idx = 2'd1;
            cmd.byte0    = 8'hC0 | {3'b000, cp_new[10:6]};
            cmd.byte1    = 8'h80 | {2'b00, cp_new[5:0]};
          end else begin
            cmd.last_idx = 2'd2;
            cmd.byte0    = 8'hE0 | {4'h0, cp_new[15:12]};
            cmd.byte1    = 8'h80 | {2'b00, cp_new[11:6]};
            cmd.byte2    = 8'h80 | {2'b00, cp_new[5:0]};
          end
        end else begin
          code_point_next = cp_new;
          hex_count_next  = hex_count + 2'd1;
        end
      end
    endcase
    // Leaving the string always clears the hex state.
    if (phase_next == PH_IDLE) begin
      hex_count_next  = 2'd0;
      code_point_next = 16'h0000;
    end
  end

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && has_result;
  assign push_cmd = cmd;

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      hex_count  <= 2'd0;
      code_point <= 16'h0000;
    end else if (accept) begin
      phase      <= phase_next;
      hex_count  <= hex_count_next;
      code_point <= code_point_next;
    end
  end

endmodule

>>> src/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue: command queue
// Small first-in first-out store between parser and output sequencer.
// ----------------------------------------------------------------------------
module jsu_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  jsu_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output jsu_pkg::cmd_t head_cmd
);
  import jsu_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full      = (count == CNT_FULL);
  assign not_empty = (count != '0);
  assign head_cmd  = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Storage write.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

>>> src/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back: output sequencer
// Expands each queued command into one to three result transfers held in
// an output register.
// ----------------------------------------------------------------------------
module jsu_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  jsu_pkg::cmd_t cmd,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output jsu_pkg::status_t out_status,
  output logic          out_last
);
  import jsu_pkg::*;

  logic [1:0] idx;
  logic       load;
  logic       is_last;
  logic [7:0] sel_byte;

  assign load    = cmd_valid && (!out_valid || out_ready);
  assign is_last = (idx == cmd.last_idx);
  assign pop     = load && is_last;

  // Pick the byte for the current position.
  always_comb begin
    case (idx)
      2'd0:    sel_byte = cmd.byte0;
      2'd1:    sel_byte = cmd.byte1;
      default: sel_byte = cmd.byte2;
    endcase
  end

  // Position counter and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else if (load) begin
      idx       <= is_last ? 2'd0 : idx + 2'd1;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= sel_byte;
      out_status <= cmd.status;
      out_last   <= is_last;
    end
  end

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the JSON string unescaper
// Feeds source bytes on the slave stream, mostly well-formed quoted strings
// with random escapes and \u code points, plus broken strings and noise.
// A predictor tracks the parse state and queues the expected output bytes
// and status results, which are compared in order on the master stream.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import jsu_pkg::*;

  localparam int RANDOM_ITEMS = 330;
  localparam int TAIL_ITEMS = 40;
  localparam int LONG_HOLD_CYCLES = 120;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] SIMPLE_ESC [8] = '{8'h22, 8'h5C, 8'h2F, "b", "f", "n", "r", "t"};

  typedef enum logic [1:0] {
    EXPECT_QUOTE,
    IN_STRING,
    AFTER_BACKSLASH,
    IN_HEX
  } parse_phase_t;

  // One source byte waiting to be sent; drain_first makes the sender wait
  // until every expected result has arrived before offering it.
  typedef struct {
    logic [7:0] data;
    bit         drain_first;
  } src_byte_t;

  typedef struct {
    logic [7:0] data;
    status_t    status;
    logic       last;
  } unesc_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] in_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;           // [7:0] out_byte
  logic [2:0]  m_tuser;           // [2:0] status
  logic        m_tlast;           // last_of_run

  src_byte_t     source_bytes [$];
  unesc_result_t expected_out [$];

  // Predictor state.
  parse_phase_t parse_phase = EXPECT_QUOTE;
  logic [1:0]   hex_count = 2'd0;
  logic [15:0]  code_point = 16'h0000;

  int  n_queued = 0;
  int  n_sent = 0;
  int  n_checked = 0;
  int  n_errors = 0;
  int  status_count [8];
  int  src_gap = 0;
  int  rx_gap = 0;
  int  src_idle_pct = 20;
  int  rx_idle_pct = 20;
  logic long_hold = 1'b0;

  json_string_unescape_utf8 dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5ns clk = ~clk;

  task automatic report_mismatch(input string msg);
    n_errors++;
    if (n_errors <= 40) $display("%0t ns mismatch: %s", $time, msg);
  endtask

  function automatic void expect_result(input logic [7:0] data, input status_t st);
    unesc_result_t r;
    r.data = data;
    r.status = st;
    r.last = 1'b0;
    expected_out.push_back(r);
  endfunction

  function automatic void back_to_idle();
    parse_phase = EXPECT_QUOTE;
    hex_count = 2'd0;
    code_point = 16'h0000;
  endfunction

  // Advances the parser by one source byte and queues the results it causes.
  function automatic void predict_unescape(input logic [7:0] b);
    int n_before;
    int digit;
    n_before = expected_out.size();
    case (parse_phase)
      EXPECT_QUOTE: begin
        if (b == CH_QUOTE) parse_phase = IN_STRING;
        else expect_result(8'h00, ST_NOQUOTE);
      end
      IN_STRING: begin
        if (b == CH_QUOTE) begin
          expect_result(8'h00, ST_DONE);
          back_to_idle();
        end else if (b == 8'h00) begin
          expect_result(8'h00, ST_UNTERM);
          back_to_idle();
        end else if (b == CH_BSLASH) begin
          parse_phase = AFTER_BACKSLASH;
        end else if (b < 8'h20) begin
          expect_result(8'h00, ST_CTRL);
          back_to_idle();
        end else begin
          expect_result(b, ST_BYTE);
        end
      end
      AFTER_BACKSLASH: begin
        parse_phase = IN_STRING;
        case (b)
          8'h00: begin
            expect_result(8'h00, ST_UNTERM);
            back_to_idle();
          end
          CH_QUOTE, CH_BSLASH, 8'h2F: expect_result(b, ST_BYTE);
          "b": expect_result(8'h08, ST_BYTE);
          "f": expect_result(8'h0C, ST_BYTE);
          "n": expect_result(8'h0A, ST_BYTE);
          "r": expect_result(8'h0D, ST_BYTE);
          "t": expect_result(8'h09, ST_BYTE);
          "u": begin
            parse_phase = IN_HEX;
            hex_count = 2'd0;
            code_point = 16'h0000;
          end
          default: begin
            expect_result(8'h00, ST_BADESC);
            back_to_idle();
          end
        endcase
      end
      default: begin
        if (b >= "0" && b <= "9") digit = b - 8'h30;
        else if (b >= "a" && b <= "f") digit = b - 8'h61 + 10;
        else if (b >= "A" && b <= "F") digit = b - 8'h41 + 10;
        else digit = -1;
        if (digit < 0) begin
          expect_result(8'h00, ST_BADHEX);
          back_to_idle();
        end else begin
          code_point = {code_point[11:0], 4'(digit)};
          if (hex_count == 2'd3) begin
            // Fourth digit: encode the code point as UTF-8.
            if (code_point <= 16'h007F) begin
              expect_result(code_point[7:0], ST_BYTE);
            end else if (code_point <= 16'h07FF) begin
              expect_result({3'b110, code_point[10:6]}, ST_BYTE);
              expect_result({2'b10, code_point[5:0]}, ST_BYTE);
            end else begin
              expect_result({4'b1110, code_point[15:12]}, ST_BYTE);
              expect_result({2'b10, code_point[11:6]}, ST_BYTE);
              expect_result({2'b10, code_point[5:0]}, ST_BYTE);
            end
            parse_phase = IN_STRING;
            hex_count = 2'd0;
            code_point = 16'h0000;
          end else begin
            hex_count = hex_count + 2'd1;
          end
        end
      end
    endcase
    if (expected_out.size() > n_before) expected_out[expected_out.size() - 1].last = 1'b1;
  endfunction

  // Stimulus construction.
  task automatic push_byte(input logic [7:0] b, input bit drain_first = 1'b0);
    src_byte_t item;
    item.data = b;
    item.drain_first = drain_first;
    source_bytes.push_back(item);
    n_queued++;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + v;
    if ($urandom_range(0, 1) == 0) return 8'h61 + v - 4'd10;
    return 8'h41 + v - 4'd10;
  endfunction

  // Pushes the top ndigits hex digits of a code point.
  task automatic push_hex(input logic [15:0] cp, input int ndigits);
    for (int i = 0; i < ndigits; i++) push_byte(hex_char(cp[15 - 4 * i -: 4]));
  endtask

  task automatic queue_string(input bit drain_first);
    int n_elems;
    int kind;
    logic [7:0] b;
    logic [15:0] cp;
    push_byte(CH_QUOTE, drain_first);
    n_elems = $urandom_range(0, 8);
    repeat (n_elems) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        // Printable or high byte that passes straight through.
        do b = 8'($urandom_range(8'h20, 8'hFF));
        while (b == CH_QUOTE || b == CH_BSLASH);
        push_byte(b);
      end else if (kind < 6) begin
        push_byte(CH_BSLASH);
        push_byte(SIMPLE_ESC[$urandom_range(0, 7)]);
      end else begin
        case ($urandom_range(0, 3))
          0: cp = 16'($urandom_range(16'h0000, 16'h007F));
          1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
          2: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
          default: begin
            case ($urandom_range(0, 5))
              0: cp = 16'h0000;
              1: cp = 16'h007F;
              2: cp = 16'h0080;
              3: cp = 16'h07FF;
              4: cp = 16'h0800;
              default: cp = 16'hFFFF;
            endcase
          end
        endcase
        push_byte(CH_BSLASH);
        push_byte("u");
        push_hex(cp, 4);
      end
    end
    // How the string ends: mostly a closing quote, otherwise an error.
    kind = $urandom_range(0, 19);
    case (kind)
      13: push_byte(8'h00);
      14: push_byte(8'($urandom_range(8'h01, 8'h1F)));
      15: begin
        push_byte(CH_BSLASH);
        do b = 8'($urandom_range(0, 255));
        while (b == 8'h00 || b == CH_QUOTE || b == CH_BSLASH || b == 8'h2F || b == "b" ||
               b == "f" || b == "n" || b == "r" || b == "t" || b == "u");
        push_byte(b);
      end
      16: begin
        push_byte(CH_BSLASH);
        push_byte(8'h00);
      end
      17: begin
        push_byte(CH_BSLASH);
        push_byte("u");
        push_hex(16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 3));
        if ($urandom_range(0, 3) == 0) b = 8'h00;
        else begin
          do b = 8'($urandom_range(0, 255));
          while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F"));
        end
        push_byte(b);
      end
      18: begin
        // Closing quote followed by stray bytes outside any string.
        push_byte(CH_QUOTE);
        repeat ($urandom_range(1, 3)) begin
          do b = 8'($urandom_range(0, 255));
          while (b == CH_QUOTE);
          push_byte(b);
        end
      end
      default: push_byte(CH_QUOTE);
    endcase
  endtask

  // Source driver: offers queued bytes and predicts each accepted transfer.
  always @(posedge clk) begin
    src_byte_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= 8'h00;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_unescape(s_tdata);
        n_sent++;
        if (n_sent % 40 == 0) src_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 20;
      end
      if (!(s_tvalid && !s_tready)) begin
        if (src_gap != 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (source_bytes.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if (source_bytes[0].drain_first && expected_out.size() != 0) begin
          s_tvalid <= 1'b0;
        end else if (source_bytes.size() > TAIL_ITEMS &&
                     $urandom_range(0, 99) < src_idle_pct) begin
          src_gap = $urandom_range(0, 15);
          s_tvalid <= 1'b0;
        end else begin
          nxt = source_bytes.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= nxt.data;
        end
      end
    end
  end

  // Result monitor: checks each result transfer and paces the ready signal.
  always @(posedge clk) begin
    unesc_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        status_count[m_tuser]++;
        if (expected_out.size() == 0) begin
          report_mismatch($sformatf("result %h/%0d with nothing expected", m_tdata, m_tuser));
        end else begin
          want = expected_out.pop_front();
          if (m_tdata != want.data)
            report_mismatch($sformatf("out_byte %h, want %h", m_tdata, want.data));
          if (m_tuser != want.status)
            report_mismatch($sformatf("status %0d, want %0d", m_tuser, want.status));
          if (m_tlast != want.last)
            report_mismatch($sformatf("last_of_run %b, want %b", m_tlast, want.last));
        end
        n_checked++;
        if (n_checked % 50 == 0) rx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
      end
      if (long_hold) begin
        m_tready <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap--;
        m_tready <= 1'b0;
      end else if (source_bytes.size() > TAIL_ITEMS && $urandom_range(0, 99) < rx_idle_pct) begin
        rx_gap = $urandom_range(0, 15);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off so the command queue fills and input stalls.
  initial begin
    while (n_sent < 80) @(posedge clk);
    long_hold <= 1'b1;
    repeat (LONG_HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  // Watchdog.
  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    logic [7:0] directed [$] = '{
      8'h00, 8'hFF,                          // no opening quote, zero and top byte
      CH_QUOTE, 8'hFF, 8'h20, 8'h1F,         // top byte, space, control byte
      CH_QUOTE, CH_BSLASH, "u", "0", "7", "f", "F",   // two-byte UTF-8
      CH_BSLASH, "u", "F", "f", "a", "9",    // three-byte UTF-8
      CH_BSLASH, 8'h01,                      // control byte after a backslash
      CH_QUOTE, CH_BSLASH, "t", CH_BSLASH, "u", "1", "g"  // bad hex digit
    };
    int n_strings;
    n_strings = 0;
    foreach (directed[i]) push_byte(directed[i]);
    while (n_queued < directed.size() + RANDOM_ITEMS) begin
      queue_string(n_strings == 8 || (n_strings % 25 == 24));
      n_strings++;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (source_bytes.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_out.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (expected_out.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_out.size()));

    $display("Sent %0d source bytes in %0d strings; checked %0d results.",
             n_sent, n_strings, n_checked);
    $display({"Results by status: byte %0d, done %0d, noquote %0d, unterm %0d, ",
              "badhex %0d, badesc %0d, ctrl %0d."},
             status_count[ST_BYTE], status_count[ST_DONE], status_count[ST_NOQUOTE],
             status_count[ST_UNTERM], status_count[ST_BADHEX], status_count[ST_BADESC],
             status_count[ST_CTRL]);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
